/* hdl/bkm_pkg.sv */
// shared types and constants of the boot keyboard key map
`timescale 1ns / 1ps
package bkm_pkg;

   // size of each key-down map, one entry per hid usage code
   localparam int KEY_COUNT_DEFAULT = 256;

   // field widths
   localparam int ACTION_W = 2;
   localparam int REPORT_W = 64;
   localparam int USAGE_W  = 8;
   localparam int BYTE_W   = 8;

   // report layout: byte 0 modifiers, byte 1 reserved, bytes 2 to 7 usages
   localparam int MOD_COUNT       = 8;
   localparam int FIRST_KEY_BYTE  = 2;
   localparam int REPORT_BYTE_CNT = 8;

   // modifier bit n sets usage MOD_BASE_USAGE + n
   localparam logic [USAGE_W-1:0] MOD_BASE_USAGE = 8'hE0;
   // usage bytes at or below this value set nothing
   localparam logic [USAGE_W-1:0] USAGE_ROLLOVER = 8'h01;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_START_FRAME = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MERGE       = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY       = 2'd2;

   // commands from the pipeline control to the key maps
   typedef struct packed {
      logic start_frame;
      logic merge;
   } map_cmd_type;

   // lookup answer for one usage
   typedef struct packed {
      logic is_down;
      logic went_down;
      logic went_up;
   } key_state_type;

endpackage

/* hdl/bkm_if.sv */
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
interface bkm_req_if
   import bkm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [REPORT_W-1:0] report_bytes;
   logic                report_complete;
   logic [USAGE_W-1:0]  key_usage;

   modport source (output valid, action, report_bytes, report_complete, key_usage,
                   input ready);
   modport sink   (input valid, action, report_bytes, report_complete, key_usage,
                   output ready);
endinterface

interface bkm_rsp_if;
   logic valid;
   logic ready;
   logic key_is_down;
   logic key_went_down;
   logic key_went_up;

   modport source (output valid, key_is_down, key_went_down, key_went_up,
                   input ready);
   modport sink   (input valid, key_is_down, key_went_down, key_went_up,
                   output ready);
endinterface

/* hdl/bkm_key_map.sv */
// current and previous key-down maps with report merge and usage lookup
`timescale 1ns / 1ps
module bkm_key_map
   import bkm_pkg::*;
#(
   parameter int KEY_COUNT = KEY_COUNT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  map_cmd_type                  cmd,
   input  logic [REPORT_W-1:0]          report_bytes,
   input  logic [$clog2(KEY_COUNT)-1:0] key_index,
   output key_state_type                key_state
);

   localparam int IDX_W = $clog2(KEY_COUNT);

   logic [KEY_COUNT-1:0] current_ff;
   logic [KEY_COUNT-1:0] current_in;
   logic [KEY_COUNT-1:0] previous_ff;
   logic [KEY_COUNT-1:0] previous_in;
   logic [KEY_COUNT-1:0] set_mask;

   // decode one report into the set of usages it presses
   always_comb begin
      logic [USAGE_W-1:0] key_byte;
      logic [IDX_W-1:0]   mod_idx;
      set_mask = '0;
      for (int m = 0; m < MOD_COUNT; m++) begin
         mod_idx = IDX_W'(MOD_BASE_USAGE + USAGE_W'(m));
         if (report_bytes[m]) begin
            set_mask[mod_idx] = 1'b1;
         end
      end
      for (int p = FIRST_KEY_BYTE; p < REPORT_BYTE_CNT; p++) begin
         key_byte = report_bytes[p*BYTE_W +: BYTE_W];
         if (key_byte > USAGE_ROLLOVER) begin
            set_mask[IDX_W'(key_byte)] = 1'b1;
         end
      end
   end

   // next map contents
   always_comb begin
      current_in  = current_ff;
      previous_in = previous_ff;
      if (cmd.start_frame) begin
         previous_in = current_ff;
         current_in  = '0;
      end else if (cmd.merge) begin
         current_in = current_ff | set_mask;
      end
   end

   // map registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff  <= '0;
         previous_ff <= '0;
      end else begin
         current_ff  <= current_in;
         previous_ff <= previous_in;
      end
   end

   // lookup of the queried usage
   always_comb begin
      key_state.is_down   = current_ff[key_index];
      key_state.went_down = current_ff[key_index] & ~previous_ff[key_index];
      key_state.went_up   = ~current_ff[key_index] & previous_ff[key_index];
   end

   // frame start empties the current map and saves it as previous
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_frame |=> (current_ff == '0) && (previous_ff == $past(current_ff)))
      else $error("frame start did not roll the maps");

   // a merge only adds keys and leaves the previous map alone
   assert property (@(posedge clock) disable iff (reset)
      (cmd.merge && !cmd.start_frame) |=>
         ((current_ff & $past(current_ff)) == $past(current_ff)) &&
         $stable(previous_ff))
      else $error("merge cleared a key or touched the previous map");

   // usages zero and one can never be pressed
   assert property (@(posedge clock) disable iff (reset)
      current_ff[1:0] == 2'b00)
      else $error("reserved usage marked down");

   // with no command the maps hold
   assert property (@(posedge clock) disable iff (reset)
      (!cmd.start_frame && !cmd.merge) |=> $stable(current_ff) && $stable(previous_ff))
      else $error("maps changed without a command");

endmodule

/* hdl/boot_keyboard_key_map_top.sv */
// boot keyboard key map: request register, key maps and response register
//
// Usage:
//   req_chan carries one item per transfer: a frame start, a merge of one
//   eight-byte boot keyboard report, or a query of one usage code. Only a
//   query produces a transfer on rsp_chan, carrying key_is_down,
//   key_went_down and key_went_up. Responses leave in request order.
//   A query is registered in the request register, then in the response
//   register. Throughput: one item per cycle while no query stalls; the
//   map updates for a report are a single pass of usage decoders into the
//   256-bit map register.
//   Reset: both maps are cleared and both channels are empty after reset.
//   Stall: a query waits in the request register while the response
//   register is full and rsp_chan.ready is low; req_chan.ready then drops.
//   Frame starts and merges never wait on the response side.
`timescale 1ns / 1ps
module boot_keyboard_key_map_top
   import bkm_pkg::*;
#(
   parameter int KEY_COUNT = KEY_COUNT_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   bkm_req_if.sink    req_chan,
   bkm_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(KEY_COUNT);

   logic                req_valid_ff;
   logic [ACTION_W-1:0] req_action_ff;
   logic [REPORT_W-1:0] req_bytes_ff;
   logic                req_complete_ff;
   logic [USAGE_W-1:0]  req_usage_ff;
   logic                rsp_valid_ff;
   key_state_type       rsp_state_ff;
   logic                advance;
   logic                is_query;
   map_cmd_type         map_cmd;
   key_state_type       lookup_state;

   // request stage moves on unless a query finds the response slot full
   assign is_query = (req_action_ff == ACT_QUERY);
   assign advance  = req_valid_ff && (!is_query || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_action_ff   <= req_chan.action;
         req_bytes_ff    <= req_chan.report_bytes;
         req_complete_ff <= req_chan.report_complete;
         req_usage_ff    <= req_chan.key_usage;
      end
   end

   // map commands
   always_comb begin
      map_cmd.start_frame = advance && (req_action_ff == ACT_START_FRAME);
      map_cmd.merge       = advance && (req_action_ff == ACT_MERGE) && req_complete_ff;
   end

   bkm_key_map #(
      .KEY_COUNT (KEY_COUNT)
   ) u_key_map (
      .clock        (clock),
      .reset        (reset),
      .cmd          (map_cmd),
      .report_bytes (req_bytes_ff),
      .key_index    (IDX_W'(req_usage_ff)),
      .key_state    (lookup_state)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && is_query) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_query) begin
         rsp_state_ff <= lookup_state;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.key_is_down   = rsp_state_ff.is_down;
   assign rsp_chan.key_went_down = rsp_state_ff.went_down;
   assign rsp_chan.key_went_up   = rsp_state_ff.went_up;

   // a query that moves on always fills the response register
   assert property (@(posedge clock) disable iff (reset)
      (advance && is_query) |=> rsp_valid_ff)
      else $error("query lost on its way to the response register");

   // a waiting query never overwrites an untaken response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_state_ff))
      else $error("pending response overwritten");

   // a held request stage means the response side is blocked by a query
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |-> (is_query && rsp_valid_ff && !rsp_chan.ready))
      else $error("request stage stalled without cause");

endmodule
